// ===== rtl/core/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int ITERS     = FRAC_BITS;
	localparam int CW        = FRAC_BITS + 4;
	localparam int QSH       = 31 - FRAC_BITS;

	localparam int KINV_Q31 = 1304065748;
	localparam int KINV_F   = (KINV_Q31 + (1 << (QSH - 1))) >> QSH;

	// arctan(2^-i) in Q31 semicircles
	localparam int ATAN_Q31 [0:29] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	// 23.44 deg and -0.833 deg in semicircles
	localparam int C_DECL = (2344 * ONE + 9000) / 18000;
	localparam int H_ANG  = -((833 * ONE + 90000) / 180000);

	typedef logic signed [CW-1:0] cw_t;

	typedef enum logic [1:0] {
		REG_LAT  = 2'd0,
		REG_LON  = 2'd1,
		REG_ZONE = 2'd2
	} reg_idx_t;

	function automatic cw_t atan_f(input int i);
		int t;
		t = ATAN_Q31[i] + (1 << (QSH - 1));
		return cw_t'(t >>> QSH);
	endfunction

	// drop FRAC_BITS, nearest with ties away from zero
	function automatic logic signed [31:0] rnd_q(input logic signed [47:0] p);
		logic [47:0] m;
		m = p[47] ? 48'(-p) : 48'(p);
		m = (m + 48'(ONE / 2)) >> FRAC_BITS;
		return p[47] ? -32'(m) : 32'(m);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sst_sincos.sv =====
`default_nettype none
module sst_sincos
	import sst_pkg::*;
(
	input  logic                   clk,
	input  logic                   ce,
	input  logic signed [FRAC_BITS:0] ang,
	output cw_t                    sn,
	output cw_t                    cs
);

	typedef logic signed [FRAC_BITS+1:0] rw_t;

	rw_t r;
	logic fl;
	cw_t x_s [0:ITERS];
	cw_t y_s [0:ITERS];
	cw_t z_s [0:ITERS];
	logic flip_s [0:ITERS];

	// fold into the right half-plane, flip the cosine afterwards
	always_comb begin
		r  = rw_t'(ang);
		fl = 1'b0;
		if (r > rw_t'(ONE / 2)) begin
			r  = rw_t'(ONE) - r;
			fl = 1'b1;
		end else if (r < -rw_t'(ONE / 2)) begin
			r  = -rw_t'(ONE) - r;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]    <= cw_t'(KINV_F);
			y_s[0]    <= '0;
			z_s[0]    <= cw_t'(r);
			flip_s[0] <= fl;
			for (int i = 0; i < ITERS; i++) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_f(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_f(i);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	assign sn = y_s[ITERS];
	assign cs = flip_s[ITERS] ? -x_s[ITERS] : x_s[ITERS];

endmodule
`default_nettype wire

// ===== rtl/core/sunrise_sunset_time.sv =====
`default_nettype none
// Sunrise and sunset clock. Write latitude, longitude (hundredths of a degree)
// and the whole-hour zone offset on the cfg port while no beat is in flight,
// then stream day-of-year beats in; each gives one beat of local sunrise and
// sunset as hour and minute. One beat is taken every cycle while no result is
// held on the output. Each beat runs through a fully pipelined chain of two
// dependent 17-stage sine/cosine CORDIC passes (the day phase, then
// declination, with latitude and horizon alongside), a 16-stage restoring
// divider, a 17-stage integer square root and a 17-stage arccosine CORDIC.
// A result held on the output freezes the whole pipeline; nothing is dropped.
// Angles run in semicircles with 16 fraction bits, times round to the nearest
// minute and wrap at midnight.
module sunrise_sunset_time
	import sst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [8:0] day_of_year
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [4:0] rise_hour, [10:5] rise_minute,
	                               // [15:11] set_hour, [21:16] set_minute
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LAT     = 96;
	localparam int EOT_DLY = 68;

	logic ce;
	logic vld_s [1:LAT];

	// configuration registers
	logic signed [14:0] lat_q;
	logic signed [15:0] lon_q;
	logic signed [4:0]  zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q  <= '0;
			lon_q  <= '0;
			zone_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LAT:  lat_q  <= cfg_data[14:0];
				REG_LON:  lon_q  <= cfg_data;
				REG_ZONE: zone_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// latitude to semicircles: lat*4096/1125 as 3*lat plus a reciprocal
	// quotient; longitude/zone to a minute offset: 60*zone - lon/25 in Q16
	logic signed [14:0] lat_c;
	logic [13:0] lat_a;
	logic [15:0] lon_a;
	logic [22:0] phi_v_q;
	logic [15:0] phi_b_q;
	logic        lat_neg_q;
	logic [18:0] lon_v_q;
	logic [26:0] lon_b_q;
	logic        lon_neg_q;
	logic signed [31:0] zone_m_q;
	logic [45:0] phi_p;
	logic [16:0] phi_m;
	logic [38:0] lon_p;
	logic [26:0] lon_m;
	logic signed [FRAC_BITS:0] phi_q;
	logic signed [31:0] corr_q;

	always_comb begin
		lat_c = lat_q;
		if (lat_q > 15'sd9000) begin
			lat_c = 15'sd9000;
		end else if (lat_q < -15'sd9000) begin
			lat_c = -15'sd9000;
		end
		lat_a = lat_c[14] ? 14'(-lat_c) : 14'(lat_c);
		lon_a = lon_q[15] ? 16'(-lon_q) : 16'(lon_q);
		phi_p = 46'(phi_v_q) * 46'd7635498;
		phi_m = 17'(17'(phi_b_q) + 17'(phi_p >> 33));
		lon_p = 39'(lon_v_q) * 39'd671089;
		lon_m = lon_b_q + 27'(lon_p >> 24);
	end

	always_ff @(posedge clk) begin
		phi_v_q   <= 23'(lat_a) * 23'd721 + 23'd562;
		phi_b_q   <= 16'(lat_a) * 16'd3;
		lat_neg_q <= lat_c[14];
		lon_v_q   <= 19'(lon_a) * 19'd11 + 19'd12;
		lon_b_q   <= 27'(lon_a) * 27'd2621;
		lon_neg_q <= lon_q[15];
		zone_m_q  <= 32'(zone_q) * 32'sd3932160;
		phi_q     <= lat_neg_q ? -(FRAC_BITS+1)'(phi_m) : (FRAC_BITS+1)'(phi_m);
		corr_q    <= zone_m_q - (lon_neg_q ? -32'(lon_m) : 32'(lon_m));
	end

	// handshake: the whole pipeline advances together
	assign ce       = m_tready | ~vld_s[LAT];
	assign s_tready = ce;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (ce) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// day phase g = 2*(day-81)/365 semicircles, as 359*|d| plus a
	// reciprocal quotient of the remainder part
	logic signed [9:0] dd;
	logic [8:0] dd_a;
	logic [13:0] ga_v_s1;
	logic [17:0] ga_b_s1;
	logic        ga_neg_s1;
	logic [29:0] g_p;
	logic [17:0] g_m;
	logic signed [18:0] g_s2;

	always_comb begin
		dd   = signed'({1'b0, s_tdata[8:0]}) - 10'sd81;
		dd_a = dd[9] ? 9'(-dd) : 9'(dd);
		g_p  = 30'(ga_v_s1) * 30'd45965;
		g_m  = ga_b_s1 + 18'(g_p >> 24);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ga_v_s1   <= 14'(dd_a) * 14'd37 + 14'd182;
			ga_b_s1   <= 18'(dd_a) * 18'd359;
			ga_neg_s1 <= dd[9];
			g_s2      <= ga_neg_s1 ? -19'(g_m) : 19'(g_m);
		end
	end

	// first CORDIC pass: sin/cos of g and sin of 2g
	logic signed [FRAC_BITS:0] ang_g;
	logic signed [FRAC_BITS:0] ang_2g;
	cw_t s_g, c_g, s_2g;

	assign ang_g  = g_s2[FRAC_BITS:0];
	assign ang_2g = signed'({g_s2[FRAC_BITS-1:0], 1'b0});

	sst_sincos u_sc_g (
		.clk (clk),
		.ce  (ce),
		.ang (ang_g),
		.sn  (s_g),
		.cs  (c_g)
	);

	sst_sincos u_sc_2g (
		.clk (clk),
		.ce  (ce),
		.ang (ang_2g),
		.sn  (s_2g),
		.cs  ()
	);

	// declination, then the second pass: declination, latitude, horizon
	logic signed [FRAC_BITS:0] decl_s20;
	logic signed [FRAC_BITS:0] ang_h;
	cw_t s_d, c_d, s_p, c_p, s_h;

	assign ang_h = (FRAC_BITS+1)'(H_ANG);

	always_ff @(posedge clk) begin
		if (ce) begin
			decl_s20 <= (FRAC_BITS+1)'(rnd_q(48'(s_g) * 48'(C_DECL)));
		end
	end

	sst_sincos u_sc_d (
		.clk (clk),
		.ce  (ce),
		.ang (decl_s20),
		.sn  (s_d),
		.cs  (c_d)
	);

	sst_sincos u_sc_p (
		.clk (clk),
		.ce  (ce),
		.ang (phi_q),
		.sn  (s_p),
		.cs  (c_p)
	);

	sst_sincos u_sc_h (
		.clk (clk),
		.ce  (ce),
		.ang (ang_h),
		.sn  (s_h),
		.cs  ()
	);

	// equation of time in Q16 minutes: (987 sin2g - 753 cosg - 150 sing)/100,
	// divided as /4 then a reciprocal /25
	logic signed [29:0] e1_s20;
	logic [25:0] e2_x_s21;
	logic        e2_neg_s21;
	logic [51:0] e3_p_s22;
	logic        e3_neg_s22;
	logic signed [23:0] e4_s23;
	logic signed [23:0] eot_d [0:EOT_DLY-1];
	logic [29:0] e1_a;

	assign e1_a = e1_s20[29] ? 30'(-e1_s20) : 30'(e1_s20);

	always_ff @(posedge clk) begin
		if (ce) begin
			e1_s20     <= 30'(s_2g) * 30'sd987 - 30'(c_g) * 30'sd753 - 30'(s_g) * 30'sd150;
			e2_x_s21   <= 26'((e1_a + 30'd50) >> 2);
			e2_neg_s21 <= e1_s20[29];
			e3_p_s22   <= 52'(e2_x_s21) * 52'd42949673;
			e3_neg_s22 <= e2_neg_s21;
			e4_s23     <= e3_neg_s22 ? -24'(e3_p_s22 >> 30) : 24'(e3_p_s22 >> 30);
			eot_d[0]   <= e4_s23;
			for (int k = 1; k < EOT_DLY; k++) begin
				eot_d[k] <= eot_d[k-1];
			end
		end
	end

	// cosine of the hour angle: num/den, clamped to one
	logic signed [39:0] p1_s38;
	logic signed [39:0] p2_s38;
	cw_t                sh_s38;
	logic signed [31:0] num_w;
	logic signed [31:0] den_w;
	logic [17:0] an_w;
	logic [17:0] ad_w;
	logic [17:0] an_s39;
	logic [17:0] ad_s39;
	logic        neg_s39;
	logic        big_s39;

	always_comb begin
		num_w = 32'(sh_s38) - rnd_q(48'(p1_s38));
		den_w = rnd_q(48'(p2_s38));
		an_w  = num_w[31] ? 18'(-num_w) : 18'(num_w);
		ad_w  = den_w[31] ? 18'(-den_w) : 18'(den_w);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p1_s38  <= 40'(s_p) * 40'(s_d);
			p2_s38  <= 40'(c_p) * 40'(c_d);
			sh_s38  <= s_h;
			an_s39  <= an_w;
			ad_s39  <= ad_w;
			neg_s39 <= num_w[31] ^ den_w[31];
			big_s39 <= an_w >= ad_w;
		end
	end

	// restoring divider: quotient of (an*2^16 + ad/2) / ad, one bit a stage
	logic [17:0] dv_rem_s [0:FRAC_BITS-1];
	logic [17:0] dv_den_s [0:FRAC_BITS-1];
	logic [FRAC_BITS-1:0] dv_quo_s [0:FRAC_BITS-1];
	logic dv_neg_s [0:FRAC_BITS-1];
	logic dv_big_s [0:FRAC_BITS-1];
	logic [17:0] dv_rem_n [0:FRAC_BITS-1];
	logic [FRAC_BITS-1:0] dv_quo_n [0:FRAC_BITS-1];

	always_comb begin
		logic [17:0] rp;
		logic [17:0] dp;
		logic [FRAC_BITS-1:0] qp;
		logic [18:0] sh;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (i == 0) begin
				rp = an_s39;
				dp = ad_s39;
				qp = '0;
			end else begin
				rp = dv_rem_s[i-1];
				dp = dv_den_s[i-1];
				qp = dv_quo_s[i-1];
			end
			sh = {rp, dp[FRAC_BITS-i]};
			if (sh >= 19'(dp)) begin
				dv_rem_n[i] = 18'(sh - 19'(dp));
				dv_quo_n[i] = {qp[FRAC_BITS-2:0], 1'b1};
			end else begin
				dv_rem_n[i] = 18'(sh);
				dv_quo_n[i] = {qp[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < FRAC_BITS; i++) begin
				dv_rem_s[i] <= dv_rem_n[i];
				dv_quo_s[i] <= dv_quo_n[i];
			end
			dv_den_s[0] <= ad_s39;
			dv_neg_s[0] <= neg_s39;
			dv_big_s[0] <= big_s39;
			for (int i = 1; i < FRAC_BITS; i++) begin
				dv_den_s[i] <= dv_den_s[i-1];
				dv_neg_s[i] <= dv_neg_s[i-1];
				dv_big_s[i] <= dv_big_s[i-1];
			end
		end
	end

	// signed cosine and its square
	logic [FRAC_BITS:0] qmag;
	logic signed [FRAC_BITS+1:0] qs_s56;
	logic [32:0] sq_s56;

	assign qmag = dv_big_s[FRAC_BITS-1] ? (FRAC_BITS+1)'(ONE)
	                                   : {1'b0, dv_quo_s[FRAC_BITS-1]};

	always_ff @(posedge clk) begin
		if (ce) begin
			qs_s56 <= dv_neg_s[FRAC_BITS-1] ? -(FRAC_BITS+2)'(qmag) : (FRAC_BITS+2)'(qmag);
			sq_s56 <= 33'(qmag) * 33'(qmag);
		end
	end

	// integer square root of 2^32 - q^2, two radicand bits a stage
	localparam int SQN = FRAC_BITS + 1;
	logic [33:0] iq_v_s [0:SQN-1];
	logic [33:0] iq_r_s [0:SQN-1];
	logic signed [FRAC_BITS+1:0] iq_c_s [0:SQN-1];
	logic [33:0] iq_v_n [0:SQN-1];
	logic [33:0] iq_r_n [0:SQN-1];

	always_comb begin
		logic [33:0] vp;
		logic [33:0] rp;
		logic [33:0] bt;
		logic [33:0] tt;
		for (int j = 0; j < SQN; j++) begin
			if (j == 0) begin
				vp = (34'd1 << (2 * FRAC_BITS)) - 34'(sq_s56);
				rp = '0;
			end else begin
				vp = iq_v_s[j-1];
				rp = iq_r_s[j-1];
			end
			bt = 34'd1 << (2 * FRAC_BITS - 2 * j);
			tt = rp + bt;
			if (vp >= tt) begin
				iq_v_n[j] = vp - tt;
				iq_r_n[j] = (rp >> 1) + bt;
			end else begin
				iq_v_n[j] = vp;
				iq_r_n[j] = rp >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int j = 0; j < SQN; j++) begin
				iq_v_s[j] <= iq_v_n[j];
				iq_r_s[j] <= iq_r_n[j];
			end
			iq_c_s[0] <= qs_s56;
			for (int j = 1; j < SQN; j++) begin
				iq_c_s[j] <= iq_c_s[j-1];
			end
		end
	end

	// arccosine by vectoring CORDIC on (q, sqrt(1-q^2))
	cw_t ac_x_s [0:ITERS];
	cw_t ac_y_s [0:ITERS];
	cw_t ac_z_s [0:ITERS];
	logic signed [FRAC_BITS+1:0] cq;
	cw_t root;

	assign cq   = iq_c_s[SQN-1];
	assign root = cw_t'(iq_r_s[SQN-1][FRAC_BITS:0]);

	always_ff @(posedge clk) begin
		if (ce) begin
			if (cq[FRAC_BITS+1]) begin
				ac_x_s[0] <= root;
				ac_y_s[0] <= -cw_t'(cq);
				ac_z_s[0] <= cw_t'(ONE / 2);
			end else begin
				ac_x_s[0] <= cw_t'(cq);
				ac_y_s[0] <= root;
				ac_z_s[0] <= '0;
			end
			for (int i = 0; i < ITERS; i++) begin
				if (ac_y_s[i] > 0) begin
					ac_x_s[i+1] <= ac_x_s[i] + (ac_y_s[i] >>> i);
					ac_y_s[i+1] <= ac_y_s[i] - (ac_x_s[i] >>> i);
					ac_z_s[i+1] <= ac_z_s[i] + atan_f(i);
				end else begin
					ac_x_s[i+1] <= ac_x_s[i] - (ac_y_s[i] >>> i);
					ac_y_s[i+1] <= ac_y_s[i] + (ac_x_s[i] >>> i);
					ac_z_s[i+1] <= ac_z_s[i] - atan_f(i);
				end
			end
		end
	end

	// times in Q16 minutes, round, wrap at 1440, split into hour and minute
	logic signed [31:0] hm_s91;
	logic signed [31:0] rs_s92;
	logic signed [31:0] ss_s92;
	logic [12:0] rpos_s93;
	logic [12:0] spos_s93;
	logic [10:0] rt_s94;
	logic [10:0] st_s94;
	logic [10:0] rt_s95;
	logic [10:0] st_s95;
	logic [4:0]  rh_s95;
	logic [4:0]  sh_s95;
	logic [4:0]  rh_s96;
	logic [5:0]  rm_s96;
	logic [4:0]  sh_s96;
	logic [5:0]  sm_s96;
	logic signed [31:0] base;
	logic signed [13:0] rmin;
	logic signed [13:0] smin;

	function automatic logic [10:0] wrap_day(input logic [12:0] p);
		if (p >= 13'd5760) begin
			return 11'(p - 13'd5760);
		end else if (p >= 13'd4320) begin
			return 11'(p - 13'd4320);
		end else if (p >= 13'd2880) begin
			return 11'(p - 13'd2880);
		end else if (p >= 13'd1440) begin
			return 11'(p - 13'd1440);
		end
		return 11'(p);
	endfunction

	function automatic logic [4:0] hour_of(input logic [10:0] t);
		logic [21:0] hp;
		hp = 22'(t) * 22'd1093;
		return 5'(hp >> 16);
	endfunction

	always_comb begin
		base = 32'sd720 * 32'(ONE) + corr_q - 32'(eot_d[EOT_DLY-1]);
		rmin = 14'(rnd_q(48'(rs_s92)));
		smin = 14'(rnd_q(48'(ss_s92)));
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hm_s91   <= 32'(ac_z_s[ITERS]) * 32'sd720;
			rs_s92   <= base - hm_s91;
			ss_s92   <= base + hm_s91;
			rpos_s93 <= 13'(rmin + 14'sd2880);
			spos_s93 <= 13'(smin + 14'sd2880);
			rt_s94   <= wrap_day(rpos_s93);
			st_s94   <= wrap_day(spos_s93);
			rt_s95   <= rt_s94;
			st_s95   <= st_s94;
			rh_s95   <= hour_of(rt_s94);
			sh_s95   <= hour_of(st_s94);
			rh_s96   <= rh_s95;
			sh_s96   <= sh_s95;
			rm_s96   <= 6'(rt_s95 - 11'(rh_s95) * 11'd60);
			sm_s96   <= 6'(st_s95 - 11'(sh_s95) * 11'd60);
		end
	end

	assign m_tdata = {2'b00, sm_s96, sh_s96, rm_s96, rh_s96};

endmodule
`default_nettype wire

// ===== verif/sunrise_sunset_time_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Day-of-year stream in, sunrise/sunset clock out. A fixed-point model of the
// solar equations inside the bench predicts each beat; results are compared
// field by field in arrival order. Location registers change only while idle.
module sunrise_sunset_time_tb;
	import sst_pkg::*;

	localparam longint UNIT      = longint'(1) << FRAC_BITS;
	localparam int     PIPE_LAT  = 96;
	localparam longint KINV_GAIN = 1304065748;

	typedef struct packed {
		logic [5:0] set_minute;
		logic [4:0] set_hour;
		logic [5:0] rise_minute;
		logic [4:0] rise_hour;
	} sun_times_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// location held by the bench, mirrors the block's registers
	logic signed [14:0] site_lat = '0;
	logic signed [15:0] site_lon = '0;
	logic signed [4:0]  site_zone = '0;

	sun_times_t   times_due[$];
	int           err_count = 0;
	int           beats_in = 0;
	int           beats_out = 0;
	int           hold_off = 0;     // cycles the receiver must still refuse
	int           rx_gap = 0;       // cycles left of a random receiver stall
	bit           rx_quiet = 1'b0;  // receiver never stalls while set, unless a hold-off is pending
	bit           tx_quiet = 1'b0;

	longint atan_tab[30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	sunrise_sunset_time u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("sunrise_sunset_time_tb: errors");
		$finish;
	end

	// ---------------- fixed-point solar model ----------------
	function automatic longint div_near(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return div_near(a * b, UNIT);
	endfunction

	function automatic longint q31_down(longint t);
		int s;
		s = 31 - FRAC_BITS;
		return (t + (longint'(1) << (s - 1))) >>> s;
	endfunction

	task automatic rotate_sc(input longint ang, output longint sn, output longint cs);
		longint r, x, y, z, xn, at;
		bit     flip;
		r = ang & (2 * UNIT - 1);
		flip = 1'b0;
		if (r >= UNIT)
			r -= 2 * UNIT;
		if (r > UNIT / 2) begin
			r = UNIT - r;
			flip = 1'b1;
		end else if (r < -UNIT / 2) begin
			r = -UNIT - r;
			flip = 1'b1;
		end
		x = q31_down(KINV_GAIN);
		y = 0;
		z = r;
		for (int i = 0; i < FRAC_BITS && i < 30; i++) begin
			at = q31_down(atan_tab[i]);
			if (z >= 0) begin
				xn = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z -= at;
			end else begin
				xn = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z += at;
			end
			x = xn;
		end
		sn = y;
		cs = flip ? -x : x;
	endtask

	function automatic longint floor_root(longint v);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint hour_angle(longint c);
		longint x, y, z, xn, t, at;
		x = c;
		z = 0;
		y = floor_root(UNIT * UNIT - c * c);
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = UNIT / 2;
		end
		for (int i = 0; i < FRAC_BITS && i < 30; i++) begin
			at = q31_down(atan_tab[i]);
			if (y > 0) begin
				xn = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z += at;
			end else begin
				xn = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z -= at;
			end
			x = xn;
		end
		return z;
	endfunction

	function automatic longint wrap_day(longint q);
		longint m;
		m = div_near(q, UNIT) % 1440;
		return m < 0 ? m + 1440 : m;
	endfunction

	task automatic predict_times(input logic [8:0] doy, output sun_times_t t);
		longint lat, dd, phi, g, decl, s_g, c_g, s_2g, c_2g, s_d, c_d, s_p, c_p;
		longint s_h, c_h, num, den, an, ad, q, hm, corr, eot, rise, sset;
		lat = site_lat;
		if (lat > 9000)
			lat = 9000;
		if (lat < -9000)
			lat = -9000;
		dd = longint'(doy) - 81;
		phi = div_near(lat * UNIT, 18000);
		g = div_near(dd * 2 * UNIT, 365);
		rotate_sc(g, s_g, c_g);
		rotate_sc(2 * g, s_2g, c_2g);
		decl = qmul(div_near(2344 * UNIT, 18000), s_g);
		rotate_sc(decl, s_d, c_d);
		rotate_sc(phi, s_p, c_p);
		rotate_sc(-div_near(833 * UNIT, 180000), s_h, c_h);
		num = s_h - qmul(s_p, s_d);
		den = qmul(c_p, c_d);
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		// quotient at or past unity saturates, zero denominator included
		q = (an >= ad) ? UNIT : div_near(an * UNIT, ad);
		if ((num < 0) != (den < 0))
			q = -q;
		hm = hour_angle(q) * 720;
		corr = 60 * longint'(site_zone) * UNIT - div_near(longint'(site_lon) * UNIT, 25);
		eot = div_near(987 * s_2g - 753 * c_g - 150 * s_g, 100);
		rise = wrap_day(720 * UNIT - hm + corr - eot);
		sset = wrap_day(720 * UNIT + hm + corr - eot);
		t.rise_hour = 5'(rise / 60);
		t.rise_minute = 6'(rise % 60);
		t.set_hour = 5'(sset / 60);
		t.set_minute = 6'(sset % 60);
	endtask

	// ---------------- checking ----------------
	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("[%0t] MISMATCH beat %0d %s: got %0d want %0d",
			$realtime, beats_out, what, got, want);
	endtask

	// receiver: short random stalls, now and then a long one, plus a long
	// hold-off on request
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (rx_quiet) begin
			m_tready <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 40) == 0) begin
			rx_gap <= $urandom_range(5, 40);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		sun_times_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[21:0];
			if (times_due.size() == 0) begin
				report_mismatch("unexpected beat", int'(m_tdata), 0);
			end else begin
				want = times_due.pop_front();
				if (got.rise_hour !== want.rise_hour)
					report_mismatch("rise_hour", got.rise_hour, want.rise_hour);
				if (got.rise_minute !== want.rise_minute)
					report_mismatch("rise_minute", got.rise_minute, want.rise_minute);
				if (got.set_hour !== want.set_hour)
					report_mismatch("set_hour", got.set_hour, want.set_hour);
				if (got.set_minute !== want.set_minute)
					report_mismatch("set_minute", got.set_minute, want.set_minute);
				if (m_tdata[23:22] !== 2'b00)
					report_mismatch("pad bits", m_tdata[23:22], 0);
			end
			beats_out++;
		end
	end

	// ---------------- stimulus ----------------
	// valid stays up between back-to-back beats; drop it only for a gap
	task automatic send_day(input logic [8:0] doy);
		sun_times_t t;
		int gap;
		if (!tx_quiet) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
				$urandom_range(0, 2);
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, doy};
		predict_times(doy, t);
		times_due.push_back(t);
		do
			@(posedge clk);
		while (!s_tready);
		beats_in++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (times_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_LAT:  site_lat = val[14:0];
			REG_LON:  site_lon = val;
			REG_ZONE: site_zone = val[4:0];
			default: ;
		endcase
	endtask

	task automatic set_site(input int lat, input int lon, input int zone);
		drain();
		write_reg(REG_LAT, 16'(lat));
		write_reg(REG_LON, 16'(lon));
		write_reg(REG_ZONE, 16'(zone));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [8:0] random_day;
		case ($urandom_range(0, 9))
			0:       return 9'($urandom);     // any 9-bit value, beyond the calendar included
			1:       return $urandom_range(0, 1) ? 9'd1 : 9'd366;
			default: return 9'($urandom_range(1, 366));
		endcase
	endfunction

	// extremes of the day field, solstices and equinoxes, at the reset site
	task automatic test_directed_days;
		logic [8:0] days[] = '{9'd1, 9'd366, 9'd0, 9'd511, 9'd81, 9'd172,
			9'd264, 9'd355, 9'd365, 9'd256, 9'd255, 9'd128};
		foreach (days[i])
			send_day(days[i]);
	endtask

	// polar day and night, latitudes past the poles, wrapping longitude and zone
	task automatic test_site_extremes;
		set_site(9000, 18000, 14);
		send_day(9'd172);
		send_day(9'd355);
		set_site(-9000, -18000, -12);
		send_day(9'd172);
		send_day(9'd355);
		set_site(16383, 32767, 15);   // clamps and out-of-range location
		send_day(9'd1);
		send_day(9'd200);
		set_site(-16384, -32768, -16);
		send_day(9'd100);
		send_day(9'd300);
		set_site(6700, 2500, 2);      // near the arctic circle
		send_day(9'd172);
		send_day(9'd355);
		send_day(9'd81);
	endtask

	// hold the receiver off while beats keep coming, so the pipe backs up
	task automatic test_backpressure;
		set_site(5150, -12, 0);
		tx_quiet = 1'b1;
		hold_off = 300;
		repeat (150)
			send_day(random_day());
		tx_quiet = 1'b0;
	endtask

	// full-rate burst with no stalls on either side
	task automatic test_full_rate;
		drain();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		repeat (60)
			send_day(random_day());
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_random_sites;
		for (int p = 0; p < 10; p++) begin
			// mostly legal sites; now and then any bit pattern
			if (p % 4 == 3)
				set_site(int'(16'($urandom)), int'(16'($urandom)), int'(5'($urandom)));
			else
				set_site($urandom_range(0, 18000) - 9000,
					$urandom_range(0, 36000) - 18000, $urandom_range(0, 26) - 12);
			repeat (40)
				send_day(random_day());
		end
	endtask

	initial begin
		int waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_days();
		test_site_extremes();
		test_backpressure();
		test_full_rate();
		test_random_sites();
		s_tvalid <= 1'b0;
		waited = 0;
		while (times_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LAT + 20) @(posedge clk);
		$display("Covered %0d day beats over polar, clamped and random sites;", beats_in);
		$display("%0d results checked, %0d still pending.", beats_out, times_due.size());
		if (err_count == 0 && times_due.size() == 0)
			$display("sunrise_sunset_time_tb: clean");
		else
			$display("sunrise_sunset_time_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
